// ===== rtl/bgc_pkg.sv =====
// ----------------------------------------------------------------------------
// bgc_pkg
// shared widths, reset values and event codes of the button gesture counter
// ----------------------------------------------------------------------------
package bgc_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int TIME_WIDTH  = 16;

	// configuration register widths and port sizes
	localparam int PERIOD_W  = 8;
	localparam int WINDOW_W  = 16;
	localparam int HOLD_W    = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	// stream payload widths
	localparam int GCOUNT_W  = 16;
	localparam int EVENT_W   = 3;
	localparam int S_DATA_W  = 8;
	localparam int M_DATA_W  = 24;
	localparam int M_USED_W  = GCOUNT_W + EVENT_W;

	// common width for age against threshold compares
	localparam int CMP_W = (TIME_WIDTH > HOLD_W) ? TIME_WIDTH : HOLD_W;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD   = 2'd2;

	// register reset values
	localparam logic [PERIOD_W-1:0] PERIOD_RST = 8'd100;
	localparam logic [WINDOW_W-1:0] WINDOW_RST = 16'd30;
	localparam logic [HOLD_W-1:0]   HOLD_RST   = 16'd50;

	// event codes
	localparam logic [EVENT_W-1:0] EV_NONE      = 3'd0;
	localparam logic [EVENT_W-1:0] EV_CLICK     = 3'd1;
	localparam logic [EVENT_W-1:0] EV_DOUBLE    = 3'd2;
	localparam logic [EVENT_W-1:0] EV_HOLD_STEP = 3'd3;
	localparam logic [EVENT_W-1:0] EV_HOLD_REL  = 3'd4;
	localparam logic [EVENT_W-1:0] EV_AUTO_DEC  = 3'd5;

	typedef logic [COUNT_WIDTH-1:0] count_t;
	typedef logic [TIME_WIDTH-1:0]  age_t;

endpackage

// ===== rtl/button_gesture_counter_top.sv =====
// ----------------------------------------------------------------------------
// button_gesture_counter_top
// Takes one sampled active-low button level per item and returns one item with
// the saturating gesture count and the event of that tick. Clicks add one, a
// second click released inside the double-click window undoes the first +1
// and doubles the count, a held button adds one per tick past the hold time,
// and after each release the count decays by one every auto-decrement period.
// One item is accepted per clock cycle while the output is not stalled by
// m_tready; its result passes through the input register, then the result
// register. The rate is set by the gesture state, which is updated once per item.
// ----------------------------------------------------------------------------
module button_gesture_counter_top
	import bgc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_DATA_W-1:0]  s_tdata,   // [0] button_level, rest zero
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_DATA_W-1:0]  m_tdata,   // [15:0] gesture_count, [18:16] event_code
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam count_t COUNT_MAX = '1;
	localparam age_t   TIME_MAX  = '1;

	// configuration
	logic [PERIOD_W-1:0] period_q;
	logic [WINDOW_W-1:0] window_q;
	logic [HOLD_W-1:0]   hold_q;

	// gesture state
	logic                last_level_q;
	count_t              count_q;
	logic [PERIOD_W-1:0] countdown_q;
	age_t                press_age_q;
	logic                window_open_q;
	age_t                window_age_q;

	// input stage
	logic valid_s1;
	logic level_s1;

	// result stage
	logic [GCOUNT_W-1:0] gcount_s2;
	logic [EVENT_W-1:0]  event_s2;

	logic advance;
	logic step;

	// next state
	logic                last_level_d;
	count_t              count_d;
	logic [PERIOD_W-1:0] countdown_d;
	age_t                press_age_d;
	logic                window_open_d;
	age_t                window_age_d;
	logic [EVENT_W-1:0]  event_d;

	assign advance  = !m_tvalid || m_tready;
	assign step     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RST;
			window_q <= WINDOW_RST;
			hold_q   <= HOLD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PERIOD: period_q <= cfg_data[PERIOD_W-1:0];
				REG_WINDOW: window_q <= cfg_data[WINDOW_W-1:0];
				REG_HOLD:   hold_q   <= cfg_data[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		logic   pressed_long;
		count_t dec;
		press_age_d   = press_age_q;
		window_age_d  = window_age_q;
		countdown_d   = countdown_q;
		count_d       = count_q;
		window_open_d = window_open_q;
		last_level_d  = last_level_q;
		event_d       = EV_NONE;

		if (!last_level_q && press_age_q != TIME_MAX)
			press_age_d = press_age_q + 1'b1;
		if (window_open_q && window_age_q != TIME_MAX)
			window_age_d = window_age_q + 1'b1;

		// auto decrement countdown
		if (countdown_q != '0) begin
			countdown_d = countdown_q - 1'b1;
			if (countdown_d == '0 && count_q != '0) begin
				count_d     = count_q - 1'b1;
				countdown_d = period_q;
				event_d     = EV_AUTO_DEC;
			end
		end

		pressed_long = CMP_W'(press_age_d) > CMP_W'(hold_q);
		dec          = (count_d != '0) ? count_d - 1'b1 : '0;

		if (level_s1 == last_level_q) begin
			if (!level_s1 && pressed_long) begin
				if (count_d != COUNT_MAX)
					count_d = count_d + 1'b1;
				event_d = EV_HOLD_STEP;
			end
		end else begin
			last_level_d = level_s1;
			if (level_s1) begin
				countdown_d = period_q;
				if (pressed_long) begin
					window_open_d = 1'b0;
					event_d       = EV_HOLD_REL;
				end else if (window_open_q &&
				             CMP_W'(window_age_d) < CMP_W'(window_q)) begin
					// double click: undo the first +1, then double with saturation
					count_d       = dec[COUNT_WIDTH-1] ? COUNT_MAX
					                                   : {dec[COUNT_WIDTH-2:0], 1'b0};
					window_open_d = 1'b0;
					event_d       = EV_DOUBLE;
				end else begin
					if (count_d != COUNT_MAX)
						count_d = count_d + 1'b1;
					window_open_d = 1'b1;
					window_age_d  = '0;
					event_d       = EV_CLICK;
				end
			end else begin
				press_age_d = '0;
				countdown_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q  <= 1'b1;
			count_q       <= '0;
			countdown_q   <= '0;
			press_age_q   <= '0;
			window_open_q <= 1'b0;
			window_age_q  <= '0;
		end else if (step) begin
			last_level_q  <= last_level_d;
			count_q       <= count_d;
			countdown_q   <= countdown_d;
			press_age_q   <= press_age_d;
			window_open_q <= window_open_d;
			window_age_q  <= window_age_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (advance)
				m_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			level_s1 <= s_tdata[0];
		if (step) begin
			gcount_s2 <= GCOUNT_W'(count_d);
			event_s2  <= event_d;
		end
	end

	assign m_tdata = {{(M_DATA_W - M_USED_W){1'b0}}, event_s2, gcount_s2};

	// the countdown is held off for the whole press
	a_no_countdown_pressed: assert property (@(posedge clk) disable iff (!arst_n)
		!last_level_q |-> countdown_q == '0)
		else $error("auto decrement countdown running while pressed");

	// a click always opens the double-click window
	a_click_opens_window: assert property (@(posedge clk) disable iff (!arst_n)
		step && event_d == EV_CLICK |=> window_open_q)
		else $error("click did not open the window");

	// a hold step never lowers the count
	a_hold_step_rises: assert property (@(posedge clk) disable iff (!arst_n)
		step && event_d == EV_HOLD_STEP |=> count_q >= $past(count_q))
		else $error("hold step lowered the count");

endmodule
